// ===== rtl/lpdfu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpdfu_pkg: shared constants and types
// Register indexes, mode codes and default timing values.
// ----------------------------------------------------------------------------
package lpdfu_pkg;
    localparam int ERROR_BLINK_COUNT = 3;
    localparam int ERROR_BLINK_MS    = 100;
    localparam int CFG_ADDR_W        = 3;
    localparam int CFG_DATA_W        = 16;
    localparam int IV_W              = 12;

    localparam logic [CFG_ADDR_W-1:0] REG_HOLD     = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_DEBOUNCE = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_START    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_END      = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_ACTIVE   = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_UPLOAD   = 3'd5;

    localparam logic [2:0] MODE_IDLE      = 3'd0;
    localparam logic [2:0] MODE_ARMING    = 3'd1;
    localparam logic [2:0] MODE_ACTIVE    = 3'd2;
    localparam logic [2:0] MODE_UPLOADING = 3'd3;
    localparam logic [2:0] MODE_UPLOADED  = 3'd4;

    localparam logic [1:0] EV_NONE    = 2'd0;
    localparam logic [1:0] EV_STARTED = 2'd1;
    localparam logic [1:0] EV_DONE    = 2'd2;
    localparam logic [1:0] EV_STOPPED = 2'd3;

    // handshake between the tick sequencer and the interval unit
    typedef struct packed {
        logic            start;
        logic [15:0]     elapsed;
    } iv_req_t;

    typedef struct packed {
        logic            busy;
        logic            done;
        logic [IV_W-1:0] interval;
    } iv_rsp_t;
endpackage

// ===== rtl/lpdfu_interval.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpdfu_interval: arming toggle interval unit
// end + (hold-elapsed)^2*(start-end)/hold^2 by bit-serial multiply and
// restoring division, one bit per cycle.
// ----------------------------------------------------------------------------
module lpdfu_interval (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  lpdfu_pkg::iv_req_t       req,
    input  logic [15:0]              hold_ms,
    input  logic [11:0]              start_ms,
    input  logic [11:0]              end_ms,
    output lpdfu_pkg::iv_rsp_t       rsp
);
    typedef enum logic [2:0] {S_IDLE, S_SQ, S_MUL, S_DEN, S_DIV, S_OUT} st_t;

    st_t         st_reg;
    logic [5:0]  cnt_reg;
    logic [15:0] rem_reg;
    logic [11:0] span_reg;
    logic [43:0] num_reg;   // rem^2*span, then quotient shifts in
    logic [31:0] mcand_reg;
    logic [31:0] den_reg;
    logic [32:0] part_reg;  // partial remainder
    logic [11:0] out_reg;
    logic        done_reg;
    logic        sat_reg;

    logic [32:0] trial;
    logic [31:0] qv;
    logic [12:0] sum;

    assign trial = {part_reg[31:0], num_reg[43]} - {1'b0, den_reg};
    assign qv    = num_reg[31:0];
    assign sum   = {1'b0, end_ms} + ((|num_reg[43:12]) ? 13'd0 : {1'b0, num_reg[11:0]});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg   <= S_IDLE;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            unique case (st_reg)
                S_IDLE: begin
                    if (req.start) begin
                        sat_reg   <= (req.elapsed >= hold_ms);
                        rem_reg   <= hold_ms - req.elapsed;
                        span_reg  <= (start_ms > end_ms) ? start_ms - end_ms : 12'd0;
                        num_reg   <= '0;
                        mcand_reg <= {16'd0, hold_ms - req.elapsed};
                        cnt_reg   <= 6'd0;
                        st_reg    <= S_SQ;
                    end
                end
                S_SQ: begin
                    // rem*rem, one multiplier bit per cycle
                    if (rem_reg[cnt_reg[3:0]])
                        num_reg <= num_reg + {12'd0, mcand_reg};
                    mcand_reg <= mcand_reg << 1;
                    cnt_reg   <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd15) begin
                        st_reg  <= S_MUL;
                        cnt_reg <= 6'd0;
                    end
                end
                S_MUL: begin
                    // square times span: shift-add over span bits
                    if (cnt_reg == 6'd0) begin
                        mcand_reg <= qv;
                        num_reg   <= '0;
                        cnt_reg   <= 6'd1;
                    end else begin
                        if (span_reg[cnt_reg[3:0] - 4'd1])
                            num_reg <= num_reg + ({12'd0, mcand_reg} << (cnt_reg[3:0] - 4'd1));
                        cnt_reg <= cnt_reg + 6'd1;
                        if (cnt_reg == 6'd12) begin
                            st_reg    <= S_DEN;
                            cnt_reg   <= 6'd0;
                            den_reg   <= '0;
                            mcand_reg <= {16'd0, hold_ms};
                        end
                    end
                end
                S_DEN: begin
                    if (hold_ms[cnt_reg[3:0]])
                        den_reg <= den_reg + mcand_reg;
                    mcand_reg <= mcand_reg << 1;
                    cnt_reg   <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd15) begin
                        st_reg   <= S_DIV;
                        cnt_reg  <= 6'd0;
                        part_reg <= '0;
                    end
                end
                S_DIV: begin
                    // restoring division, quotient bits enter at the bottom
                    if (!trial[32]) begin
                        part_reg <= trial;
                        num_reg  <= {num_reg[42:0], 1'b1};
                    end else begin
                        part_reg <= {part_reg[31:0], num_reg[43]};
                        num_reg  <= {num_reg[42:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd43)
                        st_reg <= S_OUT;
                end
                S_OUT: begin
                    if (sat_reg || den_reg == 32'd0)
                        out_reg <= (end_ms == 12'd0) ? 12'd1 : end_ms;
                    else
                        out_reg <= (sum[11:0] == 12'd0) ? 12'd1 : sum[11:0];
                    done_reg <= 1'b1;
                    st_reg   <= S_IDLE;
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end

    assign rsp.busy     = (st_reg != S_IDLE);
    assign rsp.done     = done_reg;
    assign rsp.interval = out_reg;
endmodule

// ===== rtl/long_press_dfu_arm_indicator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// long_press_dfu_arm_indicator: long-press arming with LED status
// One word per 1 ms tick in, one status word per tick out.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one word per millisecond tick carrying button_raw,
//   upload_event and entry_refused. m_ channel: one status word per tick
//   (led_on, mode, enter_request, arm_cancelled).
//   cfg_we/cfg_addr/cfg_data write the six timing registers; write only
//   while idle.
//   Sequence: a tick whose arming timer fires mid-hold runs the interval
//   unit (setup, bit-serial squaring, span multiply, denominator and
//   division steps, then an output step) before its status word is
//   registered; every other tick's status word is registered after
//   phase one (T_WAIT) and phase two (T_FINISH). The interval unit's
//   bit-serial loop sets the worst case. One word is processed at a time:
//   the next word is taken only after the previous one is finished.
//   Reset: all state idle, LED off, registers take their defaults.
//   Stall: the result sits in the output register until m_ready; no new
//   input word is taken while an untaken result waits, except in the cycle
//   in which m_ready takes it.
// ----------------------------------------------------------------------------
module long_press_dfu_arm_indicator #(
    parameter int ERR_COUNT = lpdfu_pkg::ERROR_BLINK_COUNT,
    parameter int ERR_MS    = lpdfu_pkg::ERROR_BLINK_MS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_button_raw,
    input  logic [1:0]  s_upload_event,
    input  logic        s_entry_refused,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_led_on,
    output logic [2:0]  m_mode,
    output logic        m_enter_request,
    output logic        m_arm_cancelled,
    input  logic        cfg_we,
    input  logic [lpdfu_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [lpdfu_pkg::CFG_DATA_W-1:0] cfg_data
);
    typedef enum logic [1:0] {T_IDLE, T_WAIT, T_FINISH} tst_t;

    // configuration
    logic [15:0] hold_reg;
    logic [7:0]  deb_reg;
    logic [11:0] start_reg, end_reg, act_reg, upl_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_reg  <= 16'd3000;
            deb_reg   <= 8'd30;
            start_reg <= 12'd600;
            end_reg   <= 12'd50;
            act_reg   <= 12'd500;
            upl_reg   <= 12'd100;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                lpdfu_pkg::REG_HOLD:     hold_reg  <= cfg_data;
                lpdfu_pkg::REG_DEBOUNCE: deb_reg   <= cfg_data[7:0];
                lpdfu_pkg::REG_START:    start_reg <= cfg_data[11:0];
                lpdfu_pkg::REG_END:      end_reg   <= cfg_data[11:0];
                lpdfu_pkg::REG_ACTIVE:   act_reg   <= cfg_data[11:0];
                lpdfu_pkg::REG_UPLOAD:   upl_reg   <= cfg_data[11:0];
                default: ;
            endcase
        end
    end

    // block state
    tst_t        tst_reg;
    logic [2:0]  mode_reg;
    logic [7:0]  dleft_reg;
    logic        dpend_reg, last_reg;
    logic [15:0] hel_reg;
    logic [11:0] aleft_reg;
    logic        led_reg;
    logic [11:0] bleft_reg, bhalf_reg;
    logic        brun_reg;
    logic [1:0]  bcnt_reg;
    // latched word
    logic        raw_reg, ref_reg;
    logic [1:0]  ev_reg;
    // output register
    logic        mv_reg, mled_reg, mreq_reg, mcan_reg;
    logic [2:0]  mmode_reg;

    lpdfu_pkg::iv_req_t ivq;
    lpdfu_pkg::iv_rsp_t ivr;

    lpdfu_interval u_iv (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (ivq),
        .hold_ms  (hold_reg),
        .start_ms (start_reg),
        .end_ms   (end_reg),
        .rsp      (ivr)
    );

    // phase one: blinker and arming timer; result in the _n signals, stored in T_WAIT
    logic [2:0]  mode_n;
    logic        led_n, brun_n, req_n, can_n, need_iv;
    logic [11:0] bleft_n, bhalf_n, aleft_n;
    logic [1:0]  bcnt_n;
    logic [15:0] hel_n;
    logic [11:0] eb, ab;

    assign eb = (ERR_MS[11:0] == 12'd0) ? 12'd1 : ERR_MS[11:0];
    assign ab = (act_reg == 12'd0) ? 12'd1 : act_reg;

    always_comb begin
        mode_n = mode_reg; led_n = led_reg; brun_n = brun_reg;
        bleft_n = bleft_reg; bhalf_n = bhalf_reg; bcnt_n = bcnt_reg;
        aleft_n = aleft_reg; hel_n = hel_reg;
        req_n = 1'b0; can_n = 1'b0; need_iv = 1'b0;
        if (brun_n) begin
            bleft_n = (bleft_n != 12'd0) ? bleft_n - 12'd1 : 12'd0;
            if (bleft_n == 12'd0) begin
                if (led_n) begin
                    led_n = 1'b0;
                    if (bcnt_n != 2'd0) begin
                        bcnt_n = bcnt_n - 2'd1;
                        if (bcnt_n == 2'd0) begin
                            brun_n = 1'b0; bleft_n = '0;
                        end
                    end
                end else begin
                    led_n = 1'b1;
                end
                if (brun_n) bleft_n = bhalf_n;
            end
        end
        if (aleft_n != 12'd0) begin
            if (hel_n != 16'hFFFF) hel_n = hel_n + 16'd1;
            aleft_n = aleft_n - 12'd1;
            if (aleft_n == 12'd0) begin
                if (!raw_reg) begin
                    mode_n = lpdfu_pkg::MODE_IDLE;
                    brun_n = 1'b0; bleft_n = '0; bcnt_n = '0; led_n = 1'b0;
                    can_n = 1'b1;
                end else if (hel_n >= hold_reg) begin
                    req_n = 1'b1;
                    brun_n = 1'b1; led_n = 1'b1;
                    if (ref_reg) begin
                        mode_n = lpdfu_pkg::MODE_IDLE;
                        bhalf_n = eb; bleft_n = eb; bcnt_n = ERR_COUNT[1:0];
                    end else begin
                        mode_n = lpdfu_pkg::MODE_ACTIVE;
                        bhalf_n = ab; bleft_n = ab; bcnt_n = '0;
                    end
                end else begin
                    led_n = ~led_n;
                    need_iv = 1'b1;
                end
            end
        end
    end

    // phase two: debounce and upload event, on stored state
    logic [2:0]  mode_f;
    logic        led_f, brun_f, last_f, dpend_f, can_f;
    logic [11:0] bleft_f, bhalf_f, aleft_f, ub;
    logic [1:0]  bcnt_f;
    logic [15:0] hel_f;
    logic [7:0]  dleft_f;

    assign ub = (upl_reg == 12'd0) ? 12'd1 : upl_reg;

    always_comb begin
        mode_f = mode_reg; led_f = led_reg; brun_f = brun_reg;
        bleft_f = bleft_reg; bhalf_f = bhalf_reg; bcnt_f = bcnt_reg;
        aleft_f = aleft_reg; hel_f = hel_reg; last_f = last_reg;
        dpend_f = dpend_reg; dleft_f = dleft_reg; can_f = mcan_reg;
        if (raw_reg != last_f) begin
            last_f = raw_reg;
            dleft_f = (deb_reg == 8'd0) ? 8'd1 : deb_reg;
            dpend_f = 1'b1;
        end else if (dpend_f) begin
            dleft_f = (dleft_f != 8'd0) ? dleft_f - 8'd1 : 8'd0;
            if (dleft_f == 8'd0) begin
                dpend_f = 1'b0;
                if (raw_reg) begin
                    if (mode_f == lpdfu_pkg::MODE_IDLE) begin
                        mode_f = lpdfu_pkg::MODE_ARMING;
                        hel_f = '0;
                        brun_f = 1'b0; bleft_f = '0; bcnt_f = '0;
                        led_f = 1'b1;
                        aleft_f = (start_reg == 12'd0) ? 12'd1 : start_reg;
                    end
                end else if (mode_f == lpdfu_pkg::MODE_ARMING) begin
                    mode_f = lpdfu_pkg::MODE_IDLE; aleft_f = '0;
                    brun_f = 1'b0; bleft_f = '0; bcnt_f = '0; led_f = 1'b0;
                    can_f = 1'b1;
                end
            end
        end
        case (ev_reg)
            lpdfu_pkg::EV_STARTED: begin
                if (mode_f == lpdfu_pkg::MODE_ACTIVE) begin
                    mode_f = lpdfu_pkg::MODE_UPLOADING;
                    bhalf_f = ub; bleft_f = ub; bcnt_f = '0;
                    brun_f = 1'b1; led_f = 1'b1;
                end
            end
            lpdfu_pkg::EV_DONE: begin
                mode_f = lpdfu_pkg::MODE_UPLOADED;
                brun_f = 1'b0; bleft_f = '0; bcnt_f = '0; led_f = 1'b1;
            end
            lpdfu_pkg::EV_STOPPED: begin
                if (mode_f == lpdfu_pkg::MODE_UPLOADING) begin
                    mode_f = lpdfu_pkg::MODE_ACTIVE;
                    bhalf_f = ab; bleft_f = ab; bcnt_f = '0;
                    brun_f = 1'b1; led_f = 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign s_ready   = (tst_reg == T_IDLE) && !ivr.busy && (!mv_reg || m_ready);
    assign ivq.start = (tst_reg == T_WAIT) && need_iv;
    assign ivq.elapsed = hel_n;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tst_reg   <= T_IDLE;
            mode_reg  <= lpdfu_pkg::MODE_IDLE;
            dleft_reg <= '0; dpend_reg <= 1'b0; last_reg <= 1'b0;
            hel_reg   <= '0; aleft_reg <= '0; led_reg <= 1'b0;
            bleft_reg <= '0; bhalf_reg <= '0; brun_reg <= 1'b0; bcnt_reg <= '0;
            mv_reg    <= 1'b0;
        end else begin
            if (mv_reg && m_ready) mv_reg <= 1'b0;
            unique case (tst_reg)
                T_IDLE: begin
                    // hold the word, then run phase one next cycle
                    if (s_valid && s_ready) begin
                        raw_reg <= s_button_raw;
                        ev_reg  <= s_upload_event;
                        ref_reg <= s_entry_refused;
                        tst_reg <= T_WAIT;
                    end
                end
                T_WAIT: begin
                    mode_reg <= mode_n; led_reg <= led_n; brun_reg <= brun_n;
                    bleft_reg <= bleft_n; bhalf_reg <= bhalf_n; bcnt_reg <= bcnt_n;
                    aleft_reg <= aleft_n; hel_reg <= hel_n;
                    mreq_reg <= req_n; mcan_reg <= can_n;
                    tst_reg <= T_FINISH;
                end
                T_FINISH: begin
                    // wait for a pending interval, then finish the tick;
                    // a release cancel in this tick drops the new interval
                    if (!ivr.busy) begin
                        mode_reg <= mode_f; led_reg <= led_f; brun_reg <= brun_f;
                        bleft_reg <= bleft_f; bhalf_reg <= bhalf_f;
                        bcnt_reg <= bcnt_f; hel_reg <= hel_f;
                        last_reg <= last_f; dpend_reg <= dpend_f; dleft_reg <= dleft_f;
                        aleft_reg <= (ivr.done && !can_f) ? ivr.interval : aleft_f;
                        mled_reg <= led_f; mmode_reg <= mode_f; mcan_reg <= can_f;
                        mv_reg <= 1'b1;
                        tst_reg <= T_IDLE;
                    end
                end
                default: tst_reg <= T_IDLE;
            endcase
        end
    end

    assign m_valid         = mv_reg;
    assign m_led_on        = mled_reg;
    assign m_mode          = mmode_reg;
    assign m_enter_request = mreq_reg;
    assign m_arm_cancelled = mcan_reg;

`ifndef NO_ASSERTIONS
    // never accept a word while the output still holds an untaken result
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |-> (!mv_reg || m_ready))
        else $error("input accepted over pending result");
    // a result never carries both entry request and cancel
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_enter_request && m_arm_cancelled))
        else $error("request and cancel together");
    // interval unit starts only from an idle unit
    a_iv: assert property (@(posedge aclk) disable iff (!aresetn)
        ivq.start |-> !ivr.busy)
        else $error("interval unit restarted while busy");
`endif
endmodule

// ===== test/long_press_dfu_arm_indicator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// long_press_dfu_arm_indicator_tb: self-checking bench for the arming block
// Feeds millisecond tick words through the s_ channel under random bursts and
// gaps, stalls the m_ channel on its own pattern, and compares every status
// word against a cycle-free model of the debounce, arming and blink logic.
// Runs several timing settings, including all-zero and extreme registers.
// ----------------------------------------------------------------------------
module long_press_dfu_arm_indicator_tb;

    localparam int LIMIT_CYCLES = 3000000;
    localparam int SETTLE       = 150;   // well above the longest tick, one that runs the interval unit

    typedef struct packed {
        logic       led;
        logic [2:0] mode;
        logic       enter;
        logic       cancel;
    } status_t;

    typedef struct {
        logic       raw;
        logic [1:0] ev;
        logic       refused;
        logic       chk;      // expectation typed in below
        status_t    st;
    } tick_row_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic       s_button_raw = 1'b0;
    logic [1:0] s_upload_event = lpdfu_pkg::EV_NONE;
    logic       s_entry_refused = 1'b0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic       m_led_on;
    logic [2:0] m_mode;
    logic       m_enter_request;
    logic       m_arm_cancelled;
    logic       cfg_we = 1'b0;
    logic [lpdfu_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [lpdfu_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    long_press_dfu_arm_indicator dut (.*);

    always #6 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Status model: timing registers and tick state
    // ------------------------------------------------------------------
    int unsigned hold_ms, db_ms, arm_start, arm_end, act_half, upl_half;
    int unsigned cur_mode, db_left, elapsed, arm_left;
    int unsigned blk_left, blk_half, blk_count;
    bit          db_pend, prev_raw, led, blk_run;

    status_t expected_status[$];
    int      fails = 0;
    int      words_out = 0;
    int      entries = 0;
    int      cancels = 0;
    int      cycles = 0;

    function automatic int unsigned one_min(int unsigned v);
        return (v == 0) ? 1 : v;
    endfunction

    function automatic void blink_on(int unsigned half, int unsigned count);
        blk_half  = one_min(half & 12'hFFF);
        blk_left  = blk_half;
        blk_count = count & 3;
        blk_run   = 1'b1;
        led       = 1'b1;
    endfunction

    function automatic void blink_off();
        blk_run   = 1'b0;
        blk_left  = 0;
        blk_count = 0;
        led       = 1'b0;
    endfunction

    // quadratic toggle interval, shrinking toward the end value
    function automatic int unsigned toggle_gap(int unsigned el);
        longint unsigned rem, span, den, scaled;
        if (el >= hold_ms) return one_min(arm_end);
        rem    = hold_ms - el;
        span   = (arm_start > arm_end) ? arm_start - arm_end : 0;
        den    = longint'(hold_ms) * hold_ms;
        scaled = rem * rem * span / den;
        return one_min((arm_end + int'(scaled)) & 12'hFFF);
    endfunction

    function automatic void model_reset();
        hold_ms = 3000; db_ms = 30; arm_start = 600; arm_end = 50;
        act_half = 500; upl_half = 100;
        cur_mode = lpdfu_pkg::MODE_IDLE; db_left = 0; db_pend = 0; prev_raw = 0;
        elapsed = 0; arm_left = 0; led = 0;
        blk_left = 0; blk_half = 0; blk_run = 0; blk_count = 0;
    endfunction

    function automatic status_t predict_status(logic raw, logic [1:0] ev, logic refused);
        status_t r;
        r = '0;
        // blinker countdown
        if (blk_run) begin
            blk_left = (blk_left > 0) ? blk_left - 1 : 0;
            if (blk_left == 0) begin
                if (led) begin
                    led = 1'b0;
                    if (blk_count != 0) begin
                        blk_count--;
                        if (blk_count == 0) blink_off();
                    end
                end else begin
                    led = 1'b1;
                end
                if (blk_run) blk_left = blk_half;
            end
        end
        // arming timer
        if (arm_left != 0) begin
            if (elapsed < 16'hFFFF) elapsed++;
            arm_left--;
            if (arm_left == 0) begin
                if (!raw) begin
                    cur_mode = lpdfu_pkg::MODE_IDLE; arm_left = 0; blink_off();
                    r.cancel = 1'b1;
                end else if (elapsed >= hold_ms) begin
                    r.enter = 1'b1;
                    if (refused) begin
                        cur_mode = lpdfu_pkg::MODE_IDLE;
                        blink_on(lpdfu_pkg::ERROR_BLINK_MS, lpdfu_pkg::ERROR_BLINK_COUNT);
                    end else begin
                        cur_mode = lpdfu_pkg::MODE_ACTIVE;
                        blink_on(act_half, 0);
                    end
                end else begin
                    led = ~led;
                    arm_left = toggle_gap(elapsed);
                end
            end
        end
        // debounce
        if (raw != prev_raw) begin
            prev_raw = raw;
            db_left  = one_min(db_ms);
            db_pend  = 1'b1;
        end else if (db_pend) begin
            db_left = (db_left > 0) ? db_left - 1 : 0;
            if (db_left == 0) begin
                db_pend = 1'b0;
                if (raw) begin
                    if (cur_mode == lpdfu_pkg::MODE_IDLE) begin
                        cur_mode = lpdfu_pkg::MODE_ARMING;
                        elapsed  = 0;
                        blink_off();
                        led      = 1'b1;
                        arm_left = one_min(arm_start);
                    end
                end else if (cur_mode == lpdfu_pkg::MODE_ARMING) begin
                    cur_mode = lpdfu_pkg::MODE_IDLE; arm_left = 0; blink_off();
                    r.cancel = 1'b1;
                end
            end
        end
        // upload events
        case (ev)
            lpdfu_pkg::EV_STARTED: if (cur_mode == lpdfu_pkg::MODE_ACTIVE) begin
                cur_mode = lpdfu_pkg::MODE_UPLOADING;
                blink_on(upl_half, 0);
            end
            lpdfu_pkg::EV_DONE: begin
                cur_mode = lpdfu_pkg::MODE_UPLOADED;
                blink_off();
                led = 1'b1;
            end
            lpdfu_pkg::EV_STOPPED: if (cur_mode == lpdfu_pkg::MODE_UPLOADING) begin
                cur_mode = lpdfu_pkg::MODE_ACTIVE;
                blink_on(act_half, 0);
            end
            default: ;
        endcase
        r.led  = led;
        r.mode = cur_mode[2:0];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Input monitor: predict on every accepted tick word
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            expected_status.push_back(
                predict_status(s_button_raw, s_upload_event, s_entry_refused));
    end

    // ------------------------------------------------------------------
    // Receiver: stall pattern changes with each window of the cycle count, one
    // window in four stays always ready
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        case ((cycles / 200) % 4)
            0: m_ready <= 1'b1;
            1: m_ready <= ($urandom_range(0, 1) == 1);
            2: m_ready <= (cycles % 3 == 0);
            default: m_ready <= ($urandom_range(0, 4) != 0);
        endcase
    end

    // ------------------------------------------------------------------
    // Output checker: compare each status word with the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        status_t got, want;
        if (aresetn && m_valid && m_ready) begin
            got = {m_led_on, m_mode, m_enter_request, m_arm_cancelled};
            words_out++;
            if (got.enter) entries++;
            if (got.cancel) cancels++;
            if (expected_status.size() == 0) begin
                $display("%0t: status word with nothing expected: %h", $time, got);
                fails++;
            end else begin
                want = expected_status.pop_front();
                if (got.led !== want.led) begin
                    $display("%0t: led_on expected %0d actual %0d", $time, want.led, got.led);
                    fails++;
                end
                if (got.mode !== want.mode) begin
                    $display("%0t: mode expected %0d actual %0d", $time, want.mode, got.mode);
                    fails++;
                end
                if (got.enter !== want.enter) begin
                    $display("%0t: enter_request expected %0d actual %0d",
                             $time, want.enter, got.enter);
                    fails++;
                end
                if (got.cancel !== want.cancel) begin
                    $display("%0t: arm_cancelled expected %0d actual %0d",
                             $time, want.cancel, got.cancel);
                    fails++;
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("%0t: timeout, %0d words still expected", $time, expected_status.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sender helpers
    // ------------------------------------------------------------------
    // hold the word until it is taken; valid stays high for the next word
    task automatic send_tick(logic raw, logic [1:0] ev, logic refused);
        s_valid         <= 1'b1;
        s_button_raw    <= raw;
        s_upload_event  <= ev;
        s_entry_refused <= refused;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic idle_for(int n);
        s_valid <= 1'b0;
        repeat (n) @(posedge aclk);
    endtask

    // drop valid and let every expected word come back, then let the block settle
    task automatic drain();
        s_valid <= 1'b0;
        while (expected_status.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_timing(int unsigned h, int unsigned d, int unsigned st,
                                int unsigned en, int unsigned ac, int unsigned up);
        logic [lpdfu_pkg::CFG_DATA_W-1:0] vals [6];
        vals = '{h[15:0], d[15:0], st[15:0], en[15:0], ac[15:0], up[15:0]};
        for (int i = 0; i < 6; i++) begin
            cfg_we   <= 1'b1;
            cfg_addr <= i[lpdfu_pkg::CFG_ADDR_W-1:0];
            cfg_data <= vals[i];
            @(posedge aclk);
        end
        cfg_we <= 1'b0;
        hold_ms = h & 16'hFFFF; db_ms = d & 8'hFF; arm_start = st & 12'hFFF;
        arm_end = en & 12'hFFF; act_half = ac & 12'hFFF; upl_half = up & 12'hFFF;
    endtask

    // random phase: button held in segments mostly longer than the debounce,
    // with short glitches, bursts and gaps on the sender side
    task automatic random_phase(int n, bit free_entry);
        int   burst, seg, span;
        logic lvl;
        logic [1:0] ev;
        logic ref_bit;
        burst = 0; seg = 0; lvl = prev_raw;
        span = one_min(db_ms) + ((hold_ms > 400) ? 400 : hold_ms) + 8;
        for (int i = 0; i < n; i++) begin
            if (seg == 0) begin
                lvl = ~lvl;
                seg = ($urandom_range(0, 4) == 0) ? $urandom_range(1, one_min(db_ms))
                                                  : $urandom_range(one_min(db_ms) + 1, span);
            end
            seg--;
            ev = lpdfu_pkg::EV_NONE;
            if ($urandom_range(0, free_entry ? 7 : 15) == 0) begin
                ev = 2'($urandom_range(lpdfu_pkg::EV_STARTED, lpdfu_pkg::EV_STOPPED));
                // keep upload done away until the second half of the free-entry phase: it latches the mode
                if (ev == lpdfu_pkg::EV_DONE && !(free_entry && i > n / 2))
                    ev = lpdfu_pkg::EV_STOPPED;
            end
            // an accepted entry ends arming for the rest of the run
            ref_bit = (free_entry || cur_mode != lpdfu_pkg::MODE_ARMING) ?
                      1'($urandom_range(0, 1)) : 1'b1;
            if (burst == 0) begin
                burst = $urandom_range(1, 40);
                if ($urandom_range(0, 2) != 0) idle_for($urandom_range(1, 6));
            end
            burst--;
            send_tick(lvl, ev, ref_bit);
        end
    endtask

    // ------------------------------------------------------------------
    // Directed ticks at reset timing; expectations typed in where obvious
    // ------------------------------------------------------------------
    tick_row_t dir_rows [$] = '{
        '{1'b0, lpdfu_pkg::EV_NONE,    1'b0, 1'b1, '{1'b0, lpdfu_pkg::MODE_IDLE, 1'b0, 1'b0}},
        '{1'b0, lpdfu_pkg::EV_STARTED, 1'b1, 1'b1, '{1'b0, lpdfu_pkg::MODE_IDLE, 1'b0, 1'b0}},
        '{1'b0, lpdfu_pkg::EV_STOPPED, 1'b0, 1'b1, '{1'b0, lpdfu_pkg::MODE_IDLE, 1'b0, 1'b0}},
        '{1'b1, lpdfu_pkg::EV_NONE,    1'b1, 1'b1, '{1'b0, lpdfu_pkg::MODE_IDLE, 1'b0, 1'b0}},
        '{1'b0, lpdfu_pkg::EV_NONE,    1'b0, 1'b0, '0},
        '{1'b1, lpdfu_pkg::EV_STARTED, 1'b0, 1'b0, '0},
        '{1'b1, lpdfu_pkg::EV_NONE,    1'b1, 1'b0, '0},
        '{1'b1, lpdfu_pkg::EV_STOPPED, 1'b1, 1'b0, '0},
        '{1'b0, lpdfu_pkg::EV_NONE,    1'b0, 1'b0, '0},
        '{1'b0, lpdfu_pkg::EV_NONE,    1'b1, 1'b0, '0},
        '{1'b1, lpdfu_pkg::EV_NONE,    1'b0, 1'b0, '0},
        '{1'b0, lpdfu_pkg::EV_STARTED, 1'b1, 1'b0, '0}
    };

    initial begin
        model_reset();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[k]) begin
            status_t want;
            send_tick(dir_rows[k].raw, dir_rows[k].ev, dir_rows[k].refused);
            // the monitor has predicted this tick by the next edge
            if (dir_rows[k].chk) begin
                s_valid <= 1'b0;
                @(negedge aclk);
                want = expected_status[expected_status.size() - 1];
                if (want !== dir_rows[k].st) begin
                    $display("%0t: directed tick %0d expected %h actual %h",
                             $time, k, dir_rows[k].st, want);
                    fails++;
                end
                @(posedge aclk);
            end
        end
        drain();

        // small timing so arming runs to completion many times; entry refused
        write_timing(40, 3, 12, 2, 5, 3);
        random_phase(220, 1'b0);
        drain();
        // zero registers act as one; a zero hold completes at the first firing
        write_timing(0, 0, 0, 0, 0, 0);
        random_phase(200, 1'b0);
        drain();
        // arming start below the end interval
        write_timing(60, 2, 5, 20, 7, 4);
        random_phase(200, 1'b0);
        drain();
        // longest hold: the interval math at full width
        write_timing(65535, 1, 3, 1, 2, 2);
        random_phase(200, 1'b0);
        drain();
        // widest registers: slow settle and long first toggle
        write_timing(200, 255, 4095, 4095, 4095, 4095);
        random_phase(120, 1'b0);
        drain();
        // lowest nonzero timing, then free entry and all upload events
        write_timing(1, 1, 1, 1, 1, 1);
        random_phase(150, 1'b0);
        drain();
        write_timing(30, 2, 10, 1, 6, 3);
        random_phase(220, 1'b1);
        drain();

        $display("Run covered %0d status words over seven timing settings,", words_out);
        $display("with %0d entry requests and %0d arming cancels.", entries, cancels);
        if (fails == 0 && expected_status.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
